// ===== hw/rtl/urxlb_pkg.sv =====
package urxlb_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;
    localparam int CREDIT_SHIFT_DEF = 4;

    localparam logic [7:0] CANCEL_BYTE = 8'h03;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [3:0] OVERRUN_BIT = 4'h8;

    typedef enum logic [2:0] {
        CMD_RX      = 3'd0,
        CMD_PEEK    = 3'd1,
        CMD_CONSUME = 3'd2,
        CMD_ERRORS  = 3'd3,
        CMD_START   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } t_state;

endpackage

// ===== hw/rtl/uart_rx_line_buffer_credit_ack_core.sv =====
// UART receive ring buffer with line counting and credit acks.
// Request channel: i_valid/o_ready with i_cmd, i_rx_byte, i_byte_present,
// i_line_flags and i_amount. Response channel: o_valid/i_ready, one
// response per request, carrying peek data, bytes and lines held, sticky
// errors, the ack byte and the fault and bad_request flags.
// Receive, peek, error read, start, rejected and empty consume requests move
// from idle to the finish state, which loads their response into the output
// register once it is free. A consume of a nonzero amount first passes through
// the walk state, which reads one held byte per cycle from the byte store
// through its single registered read port to update the line count and detect
// credit boundaries. No new request is taken before the response is loaded.
// A new request is taken while the previous response waits in the output
// register; when the receiver stalls, the finished request waits in the
// block and o_ready stays low until the output register frees up.
// Reset empties the ring, clears the line count and sticky errors and
// drops any pending response. The byte store itself is not cleared; only
// held bytes are ever read back.
module uart_rx_line_buffer_credit_ack_core #(
    parameter int BUFFER_DEPTH = urxlb_pkg::BUFFER_DEPTH_DEF,
    parameter int CREDIT_SHIFT = urxlb_pkg::CREDIT_SHIFT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    input  logic       i_byte_present,
    input  logic [2:0] i_line_flags,
    input  logic [7:0] i_amount,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_peek_byte,
    output logic [7:0] o_chars_held,
    output logic [7:0] o_lines_held,
    output logic [3:0] o_error_bits,
    output logic       o_ack_valid,
    output logic [7:0] o_ack_byte,
    output logic       o_fault,
    output logic       o_bad_request
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam logic [IW-1:0] LAST_IDX    = IW'(BUFFER_DEPTH - 1);
    localparam logic [IW:0]   DEPTH_W     = (IW + 1)'(BUFFER_DEPTH);
    localparam logic [IW-1:0] CREDIT_MASK = IW'((1 << CREDIT_SHIFT) - 1);
    localparam logic [7:0]    ACK_BASE    = 8'((32'hFF << CREDIT_SHIFT) & 32'hFF);

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    logic [7:0] mem [BUFFER_DEPTH];

    urxlb_pkg::t_state r_state;
    logic [IW-1:0] r_head, r_tail, r_raddr;
    logic [7:0]    r_lines;
    logic [3:0]    r_err;
    logic [7:0]    r_issue_left, r_retire_left;
    logic          r_rd_pend;
    logic [7:0]    r_rdata;

    logic          r_p_peek, r_p_ack_valid, r_p_fault, r_p_bad;
    logic [3:0]    r_p_err;
    logic [7:0]    r_p_ack_byte;

    logic          r_out_valid;
    logic [7:0]    r_o_peek, r_o_chars, r_o_lines, r_o_ack_byte;
    logic [3:0]    r_o_err;
    logic          r_o_ack_valid, r_o_fault, r_o_bad;

    logic          accept, full, is_cancel, is_eol_in, walk_eol;
    logic          peek_ok, cons_ok, issue, retire, out_load, mem_we, mem_re;
    logic [IW:0]   held_ext, peek_sum, peek_wrap;
    logic [IW-1:0] held, n_tail, n_head, peek_addr, mem_raddr;
    logic [7:0]    held8;
    logic [3:0]    n_err_rx;

    assign o_ready   = (r_state == urxlb_pkg::ST_IDLE);
    assign accept    = i_valid && o_ready;

    assign held_ext  = {1'b0, r_tail} - {1'b0, r_head}
                       + ((r_tail >= r_head) ? '0 : DEPTH_W);
    assign held      = held_ext[IW-1:0];
    assign held8     = 8'(held);
    assign n_tail    = wrap_inc(r_tail);
    assign n_head    = wrap_inc(r_head);
    assign full      = (n_tail == r_head);
    assign is_cancel = (i_rx_byte == urxlb_pkg::CANCEL_BYTE);
    assign is_eol_in = (i_rx_byte == urxlb_pkg::CR_BYTE) || (i_rx_byte == urxlb_pkg::LF_BYTE);
    assign walk_eol  = (r_rdata == urxlb_pkg::CR_BYTE) || (r_rdata == urxlb_pkg::LF_BYTE);
    assign n_err_rx  = r_err | {1'b0, i_line_flags}
                       | ((i_byte_present && !is_cancel && full) ? urxlb_pkg::OVERRUN_BIT : 4'h0);

    assign peek_ok   = (i_amount < held8);
    assign cons_ok   = (i_amount <= held8);
    assign peek_sum  = {1'b0, r_head} + (IW + 1)'(i_amount);
    assign peek_wrap = peek_sum - DEPTH_W;
    assign peek_addr = (peek_sum >= DEPTH_W) ? peek_wrap[IW-1:0] : peek_sum[IW-1:0];

    assign issue     = (r_state == urxlb_pkg::ST_WALK) && (r_issue_left != 8'd0);
    assign retire    = (r_state == urxlb_pkg::ST_WALK) && r_rd_pend;
    assign out_load  = (r_state == urxlb_pkg::ST_FINISH) && (!r_out_valid || i_ready);

    assign mem_we    = accept && (i_cmd == urxlb_pkg::CMD_RX)
                       && i_byte_present && !is_cancel && !full;
    assign mem_re    = (accept && (i_cmd == urxlb_pkg::CMD_PEEK) && peek_ok) || issue;
    assign mem_raddr = issue ? r_raddr : peek_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_tail] <= i_rx_byte;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= urxlb_pkg::ST_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_lines       <= '0;
            r_err         <= '0;
            r_issue_left  <= '0;
            r_retire_left <= '0;
            r_rd_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                urxlb_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_state       <= urxlb_pkg::ST_FINISH;
                        r_p_peek      <= 1'b0;
                        r_p_ack_valid <= 1'b0;
                        r_p_ack_byte  <= '0;
                        r_p_fault     <= 1'b0;
                        r_p_bad       <= 1'b0;
                        r_p_err       <= r_err;
                        unique case (i_cmd)
                            urxlb_pkg::CMD_RX: begin
                                r_err   <= n_err_rx;
                                r_p_err <= n_err_rx;
                                if (i_byte_present) begin
                                    if (is_cancel) begin
                                        r_p_fault <= 1'b1;
                                    end else if (!full) begin
                                        r_tail <= n_tail;
                                        if (is_eol_in) begin
                                            r_lines <= r_lines + 8'd1;
                                        end
                                    end
                                end
                            end
                            urxlb_pkg::CMD_PEEK: begin
                                if (peek_ok) begin
                                    r_p_peek <= 1'b1;
                                end else begin
                                    r_p_bad <= 1'b1;
                                end
                            end
                            urxlb_pkg::CMD_CONSUME: begin
                                if (!cons_ok) begin
                                    r_p_bad <= 1'b1;
                                end else if (i_amount != 8'd0) begin
                                    r_state       <= urxlb_pkg::ST_WALK;
                                    r_raddr       <= r_head;
                                    r_issue_left  <= i_amount;
                                    r_retire_left <= i_amount;
                                end
                            end
                            urxlb_pkg::CMD_ERRORS: begin
                                r_err <= '0;
                            end
                            urxlb_pkg::CMD_START: begin
                                r_head        <= '0;
                                r_tail        <= '0;
                                r_lines       <= '0;
                                r_p_ack_valid <= 1'b1;
                                r_p_ack_byte  <= ACK_BASE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                urxlb_pkg::ST_WALK: begin
                    r_rd_pend <= issue;
                    if (issue) begin
                        r_raddr      <= wrap_inc(r_raddr);
                        r_issue_left <= r_issue_left - 8'd1;
                    end
                    if (retire) begin
                        if (walk_eol) begin
                            r_lines <= r_lines - 8'd1;
                        end
                        r_head        <= n_head;
                        r_retire_left <= r_retire_left - 8'd1;
                        if ((n_head & CREDIT_MASK) == '0) begin
                            r_p_ack_valid <= 1'b1;
                            r_p_ack_byte  <= ACK_BASE | 8'(n_head >> CREDIT_SHIFT);
                        end
                        if (r_retire_left == 8'd1) begin
                            r_state <= urxlb_pkg::ST_FINISH;
                        end
                    end
                end
                urxlb_pkg::ST_FINISH: begin
                    if (out_load) begin
                        r_state <= urxlb_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= urxlb_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_peek      <= r_p_peek ? r_rdata : 8'd0;
            r_o_chars     <= held8;
            r_o_lines     <= r_lines;
            r_o_err       <= r_p_err;
            r_o_ack_valid <= r_p_ack_valid;
            r_o_ack_byte  <= r_p_ack_byte;
            r_o_fault     <= r_p_fault;
            r_o_bad       <= r_p_bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_peek_byte   = r_o_peek;
    assign o_chars_held  = r_o_chars;
    assign o_lines_held  = r_o_lines;
    assign o_error_bits  = r_o_err;
    assign o_ack_valid   = r_o_ack_valid;
    assign o_ack_byte    = r_o_ack_byte;
    assign o_fault       = r_o_fault;
    assign o_bad_request = r_o_bad;

`ifndef SYNTHESIS
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_o_bad && (r_o_ack_valid || r_o_fault || r_o_peek != 8'd0)))
        else $error("bad request response carries other flags");

    a_walk_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == urxlb_pkg::ST_WALK) |->
            (r_retire_left != 8'd0 && r_retire_left >= r_issue_left))
        else $error("consume walk counters out of order");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (!full && r_state == urxlb_pkg::ST_IDLE))
        else $error("byte store written while full or busy");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == urxlb_pkg::CMD_START) |=>
            (r_head == '0 && r_tail == '0 && r_lines == 8'd0))
        else $error("start did not empty the ring");
`endif

endmodule
